FILE: rtl/core/gpio_pkg.sv
// shared types, constants and mask helpers for the gpio port
package gpio_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned CODE_W        = 2;
  localparam int unsigned PINS_PER_CFG  = 16;
  localparam int unsigned PIN_COUNT_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DATA     = 3'd0,
    REG_DIR      = 3'd1,
    REG_CFG_LOW  = 3'd2,
    REG_CFG_HIGH = 3'd3,
    REG_MASK     = 3'd4,
    REG_STATUS   = 3'd5,
    REG_BOTHEDGE = 3'd6
  } reg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    TRIG_LOW  = 2'd0,
    TRIG_HIGH = 2'd1,
    TRIG_RISE = 2'd2,
    TRIG_FALL = 2'd3
  } trig_t;

  // interrupt configuration seen by the detector
  typedef struct packed {
    logic [DATA_W-1:0] both_edge;
    logic [DATA_W-1:0] cfg_high;
    logic [DATA_W-1:0] cfg_low;
  } irq_cfg_t;

  // one bit for each implemented pin
  function automatic logic [DATA_W-1:0] pin_mask_f(input int unsigned n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  // code fields of a cfg register whose first pin is first
  function automatic logic [DATA_W-1:0] cfg_mask_f(input int unsigned first,
                                                   input int unsigned n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < PINS_PER_CFG; i++) begin
      if (first + i < n) m[CODE_W*i +: CODE_W] = '1;
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/gpio_if.sv
// request and response channel interfaces of the gpio port
interface gpio_req_if;
  import gpio_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] pad_levels;

  modport source (output valid, kind, reg_index, write_data, pad_levels, input ready);
  modport sink   (input valid, kind, reg_index, write_data, pad_levels, output ready);
endinterface

interface gpio_rsp_if;
  import gpio_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [DATA_W-1:0] pins_out;
  logic [DATA_W-1:0] pins_drive_enable;
  logic              irq_pending;

  modport source (output valid, read_data, pins_out, pins_drive_enable, irq_pending,
                  input ready);
  modport sink   (input valid, read_data, pins_out, pins_drive_enable, irq_pending,
                  output ready);
endinterface

FILE: rtl/core/gpio_detect.sv
// per-pin level and edge detection for one pad sample
module gpio_detect (
  input  gpio_pkg::irq_cfg_t                cfg,
  input  logic [gpio_pkg::DATA_W-1:0]       pads,
  input  logic [gpio_pkg::DATA_W-1:0]       last_pads,
  output logic [gpio_pkg::DATA_W-1:0]       hit
);
  import gpio_pkg::*;

  for (genvar p = 0; p < DATA_W; p++) begin : g_pin
    trig_t code;

    if (p < PINS_PER_CFG) begin : g_low
      assign code = trig_t'(cfg.cfg_low[CODE_W*p +: CODE_W]);
    end else begin : g_high
      assign code = trig_t'(cfg.cfg_high[CODE_W*(p-PINS_PER_CFG) +: CODE_W]);
    end

    always_comb begin
      if (cfg.both_edge[p]) begin
        hit[p] = pads[p] ^ last_pads[p];
      end else begin
        case (code)
          TRIG_LOW:  hit[p] = ~pads[p];
          TRIG_HIGH: hit[p] = pads[p];
          TRIG_RISE: hit[p] = ~last_pads[p] & pads[p];
          TRIG_FALL: hit[p] = last_pads[p] & ~pads[p];
          default:   hit[p] = 1'b0;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/gpio_port_with_interrupt_detect.sv
// gpio port top level: register file, pad sampling, interrupt status and response register
// Each request is a pad sample tick, a register read or a register write, and each
// produces exactly one response in the cycle after it is accepted. A request can be taken
// every clock (one item per cycle): the response register is the only stage, and req.ready
// is low only while a response is held because rsp.ready is low. A tick latches the pad
// levels and sets status bits per pin by its 2-bit code (low level, high level, rising,
// falling), or on any change when its both-edge bit is set. Writing status clears the bits
// written as one; a data read returns driven bits for output pins and the last sampled
// levels for input pins. Every response carries pins_out, pins_drive_enable and
// irq_pending as they stand after the request's update; irq_pending is the OR of the status
// bits that mask enables. Register index seven reads zero and ignores writes; kind three
// does nothing. Pins at or above PIN_COUNT stay zero in every register.
module gpio_port_with_interrupt_detect #(
  parameter int unsigned PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gpio_req_if.sink   req,
  gpio_rsp_if.source rsp
);
  import gpio_pkg::*;

  localparam logic [DATA_W-1:0] PIN_MASK  = pin_mask_f(PIN_COUNT);
  localparam logic [DATA_W-1:0] CFG_LMASK = cfg_mask_f(0, PIN_COUNT);
  localparam logic [DATA_W-1:0] CFG_HMASK = cfg_mask_f(PINS_PER_CFG, PIN_COUNT);

  // architectural state
  logic [DATA_W-1:0] data_bits,      data_bits_next;
  logic [DATA_W-1:0] direction_bits, direction_bits_next;
  logic [DATA_W-1:0] cfg_low,        cfg_low_next;
  logic [DATA_W-1:0] cfg_high,       cfg_high_next;
  logic [DATA_W-1:0] mask_bits,      mask_bits_next;
  logic [DATA_W-1:0] status_bits,    status_bits_next;
  logic [DATA_W-1:0] both_edge,      both_edge_next;
  logic [DATA_W-1:0] last_pads,      last_pads_next;

  logic              accept;
  logic [DATA_W-1:0] pads_in;
  logic [DATA_W-1:0] hit;
  logic [DATA_W-1:0] read_value;
  irq_cfg_t          irq_cfg;

  // a held response blocks new requests only until it is taken
  assign req.ready = ~rsp.valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  assign pads_in = req.pad_levels & PIN_MASK;

  assign irq_cfg.both_edge = both_edge;
  assign irq_cfg.cfg_high  = cfg_high;
  assign irq_cfg.cfg_low   = cfg_low;

  gpio_detect u_detect (
    .cfg       (irq_cfg),
    .pads      (pads_in),
    .last_pads (last_pads),
    .hit       (hit)
  );

  // register read mux, from the state before this request
  always_comb begin
    unique case (reg_idx_t'(req.reg_index))
      REG_DATA:     read_value = (data_bits & direction_bits) | (last_pads & ~direction_bits);
      REG_DIR:      read_value = direction_bits;
      REG_CFG_LOW:  read_value = cfg_low;
      REG_CFG_HIGH: read_value = cfg_high;
      REG_MASK:     read_value = mask_bits;
      REG_STATUS:   read_value = status_bits;
      REG_BOTHEDGE: read_value = both_edge;
      default:      read_value = '0;
    endcase
  end

  // state update for the request being accepted
  always_comb begin
    data_bits_next      = data_bits;
    direction_bits_next = direction_bits;
    cfg_low_next        = cfg_low;
    cfg_high_next       = cfg_high;
    mask_bits_next      = mask_bits;
    status_bits_next    = status_bits;
    both_edge_next      = both_edge;
    last_pads_next      = last_pads;
    if (accept) begin
      unique case (kind_t'(req.kind))
        KIND_TICK: begin
          status_bits_next = (status_bits | hit) & PIN_MASK;
          last_pads_next   = pads_in;
        end
        KIND_WRITE: begin
          unique case (reg_idx_t'(req.reg_index))
            REG_DATA:     data_bits_next      = req.write_data & PIN_MASK;
            REG_DIR:      direction_bits_next = req.write_data & PIN_MASK;
            REG_CFG_LOW:  cfg_low_next        = req.write_data & CFG_LMASK;
            REG_CFG_HIGH: cfg_high_next       = req.write_data & CFG_HMASK;
            REG_MASK:     mask_bits_next      = req.write_data & PIN_MASK;
            REG_STATUS:   status_bits_next    = status_bits & ~req.write_data;
            REG_BOTHEDGE: both_edge_next      = req.write_data & PIN_MASK;
            default:      ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits      <= '0;
      direction_bits <= '0;
      cfg_low        <= '0;
      cfg_high       <= '0;
      mask_bits      <= '0;
      status_bits    <= '0;
      both_edge      <= '0;
      last_pads      <= '0;
    end else begin
      data_bits      <= data_bits_next;
      direction_bits <= direction_bits_next;
      cfg_low        <= cfg_low_next;
      cfg_high       <= cfg_high_next;
      mask_bits      <= mask_bits_next;
      status_bits    <= status_bits_next;
      both_edge      <= both_edge_next;
      last_pads      <= last_pads_next;
    end
  end

  // response register: valid is control, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_data         <= (kind_t'(req.kind) == KIND_READ) ? read_value : '0;
      rsp.pins_out          <= data_bits_next;
      rsp.pins_drive_enable <= direction_bits_next;
      rsp.irq_pending       <= |(status_bits_next & mask_bits_next);
    end
  end

  // every accepted request shows up as a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted request produced no response");

  // irq in a fresh response agrees with the state it was taken from
  a_irq_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.irq_pending == |(status_bits & mask_bits)))
    else $error("irq_pending disagrees with status and mask");

  // a status write clears every bit written as one
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_t'(req.kind) == KIND_WRITE && reg_idx_t'(req.reg_index) == REG_STATUS)
    |=> ((status_bits & $past(req.write_data)) == '0))
    else $error("status write left a written bit set");

  // a tick stores the masked pad sample for the next edge compare
  a_tick_sample: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_t'(req.kind) == KIND_TICK)
    |=> (last_pads == ($past(req.pad_levels) & PIN_MASK)))
    else $error("tick did not store the pad sample");

  // unimplemented pins never carry status
  a_status_pins: assert property (@(posedge clk) disable iff (rst)
    (status_bits & ~PIN_MASK) == '0)
    else $error("status set on an unimplemented pin");

endmodule
